@@ sv/tshc_pkg.sv @@
// Shared types and constants of the turn signal and hazard controller.
`default_nettype none

package tshc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int FLASH_W  = 14;
  localparam int CMD_W    = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_PERIOD_RESET = 10'd50;
  localparam logic [FLASH_W-1:0]  FLASH_HALF_RESET    = 14'd500;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_IDX_SAMPLE = 1'b0;
  localparam logic REG_IDX_FLASH  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_HAZARD = 2'd3
  } tshc_mode_e;

  localparam logic [CMD_W-1:0] CMD_MAX = 8'd3;

  typedef struct packed {
    logic             btn_left_level;
    logic             btn_right_level;
    logic             btn_hazard_level;
    logic [CMD_W-1:0] remote_cmd;
  } tshc_item_t;

  typedef struct packed {
    logic       led_left;
    logic       led_right;
    tshc_mode_e mode;
    logic [1:0] status_reports;
  } tshc_result_t;

endpackage

`default_nettype wire

@@ sv/tshc_if.sv @@
// Stream interfaces for tick words in and lamp status words out.
`default_nettype none

interface tshc_in_if;
  logic       valid;
  logic       ready;
  logic       btn_left_level;
  logic       btn_right_level;
  logic       btn_hazard_level;
  logic [7:0] remote_cmd;

  modport source (
    output valid, btn_left_level, btn_right_level, btn_hazard_level, remote_cmd,
    input  ready
  );
  modport sink (
    input  valid, btn_left_level, btn_right_level, btn_hazard_level, remote_cmd,
    output ready
  );
endinterface

interface tshc_out_if;
  logic       valid;
  logic       ready;
  logic       led_left;
  logic       led_right;
  logic [1:0] mode;
  logic [1:0] status_reports;

  modport source (
    output valid, led_left, led_right, mode, status_reports,
    input  ready
  );
  modport sink (
    input  valid, led_left, led_right, mode, status_reports,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/tshc_core.sv @@
// Controller state and the single-pass next-state logic for one tick word.
`default_nettype none

module tshc_core
  import tshc_pkg::*;
#(
  parameter int TIMER_BITS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire tshc_item_t          item_i,
  input  wire logic [SAMPLE_W-1:0] sample_period_i,
  input  wire logic [FLASH_W-1:0]  flash_half_i,
  output tshc_result_t             result_o
);

  localparam int CMP_W = (TIMER_BITS > FLASH_W) ? TIMER_BITS : FLASH_W;

  tshc_mode_e            turn_mode_q, turn_mode_d;
  logic                  flash_phase_q, flash_phase_d;
  logic [TIMER_BITS-1:0] flash_elapsed_q, flash_elapsed_d;
  logic [SAMPLE_W-1:0]   sample_elapsed_q, sample_elapsed_d;
  logic [2:0]            prev_q, prev_d;
  logic [CMD_W-1:0]      last_remote_q, last_remote_d;

  logic [2:0]       btn;
  tshc_mode_e       which [3];
  logic [1:0]       reports;
  logic [CMP_W-1:0] flash_cmp;
  logic [CMP_W-1:0] half_cmp;

  assign btn      = {item_i.btn_hazard_level, item_i.btn_right_level, item_i.btn_left_level};
  assign which[0] = MODE_LEFT;
  assign which[1] = MODE_RIGHT;
  assign which[2] = MODE_HAZARD;

  always_comb begin
    turn_mode_d   = turn_mode_q;
    flash_phase_d = flash_phase_q;
    prev_d        = prev_q;
    last_remote_d = last_remote_q;
    reports       = 2'd0;

    sample_elapsed_d = (sample_elapsed_q != '1) ? sample_elapsed_q + SAMPLE_W'(1)
                                                : sample_elapsed_q;
    flash_elapsed_d  = (flash_elapsed_q != '1) ? flash_elapsed_q + TIMER_BITS'(1)
                                               : flash_elapsed_q;

    if (item_i.remote_cmd != last_remote_q) begin
      last_remote_d = item_i.remote_cmd;
      if (item_i.remote_cmd <= CMD_MAX) begin
        turn_mode_d     = tshc_mode_e'(item_i.remote_cmd[1:0]);
        flash_phase_d   = 1'b1;
        flash_elapsed_d = '0;
      end
    end

    // Buttons are looked at only on a sample tick; edges go left, right, hazard.
    if (sample_elapsed_d >= sample_period_i) begin
      for (int b = 0; b < 3; b++) begin
        if (!btn[b] && prev_q[b]) begin
          reports = reports + 2'd1;
          if (turn_mode_d == which[b]) begin
            turn_mode_d = MODE_OFF;
          end else begin
            turn_mode_d     = which[b];
            flash_phase_d   = 1'b1;
            flash_elapsed_d = '0;
          end
        end
      end
      prev_d           = btn;
      sample_elapsed_d = '0;
    end

    flash_cmp = CMP_W'(flash_elapsed_d);
    half_cmp  = CMP_W'(flash_half_i);
    if (flash_cmp >= half_cmp) begin
      flash_phase_d   = ~flash_phase_d;
      flash_elapsed_d = '0;
    end

    result_o.led_left       = flash_phase_d &&
                              (turn_mode_d == MODE_LEFT || turn_mode_d == MODE_HAZARD);
    result_o.led_right      = flash_phase_d &&
                              (turn_mode_d == MODE_RIGHT || turn_mode_d == MODE_HAZARD);
    result_o.mode           = turn_mode_d;
    result_o.status_reports = reports;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_mode_q      <= MODE_OFF;
      flash_phase_q    <= 1'b0;
      flash_elapsed_q  <= '0;
      sample_elapsed_q <= '0;
      prev_q           <= 3'b111;
      last_remote_q    <= '0;
    end else if (step_i) begin
      turn_mode_q      <= turn_mode_d;
      flash_phase_q    <= flash_phase_d;
      flash_elapsed_q  <= flash_elapsed_d;
      sample_elapsed_q <= sample_elapsed_d;
      prev_q           <= prev_d;
      last_remote_q    <= last_remote_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/turn_signal_hazard_controller.sv @@
// Top level of the turn signal and hazard controller with its register port.
//
// Each input word is one millisecond tick: three active-low button levels and
// a remote command byte. Each accepted word gives exactly one output word with
// the two lamp drives, the current mode and the number of button presses that
// changed the mode during that tick.
// An accepted word is held in an input register; once the output register is
// empty or being drained, the whole tick is evaluated in one pass and lands in
// the output register, where the result is offered to the receiver.
// A new word is accepted every cycle while the receiver takes the results. The
// rate is set by the single-pass state update, closed on itself tick to tick.
// When the receiver stalls, the output register holds its word and the input
// register still takes one more word; only then does ready drop.
// Reset clears both stages, sets the mode to off with the lamps dark, marks
// all buttons released and loads sample period 50 and flash half period 500.
// The APB port holds the sample period at byte 0 and the flash half period at
// byte 4; write them only while no tick is in flight.
`default_nettype none

module turn_signal_hazard_controller
  import tshc_pkg::*;
#(
  parameter int TIMER_BITS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tshc_in_if.sink          in_if,
  tshc_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [SAMPLE_W-1:0] sample_period_q;
  logic [FLASH_W-1:0]  flash_half_q;
  logic                cfg_write;

  logic         s1_valid_q;
  tshc_item_t   s1_item_q;
  logic         s1_advance;
  logic         in_ready;
  logic         out_valid_q;
  tshc_result_t out_res_q;
  tshc_result_t res_d;

  // Configuration registers. The low address bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= SAMPLE_PERIOD_RESET;
      flash_half_q    <= FLASH_HALF_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_IDX_SAMPLE: sample_period_q <= pwdata[SAMPLE_W-1:0];
        REG_IDX_FLASH:  flash_half_q    <= pwdata[FLASH_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_SAMPLE: prdata = 32'(sample_period_q);
      REG_IDX_FLASH:  prdata = 32'(flash_half_q);
      default:        prdata = '0;
    endcase
  end

  // The input stage moves on when the output register is empty or being drained.
  assign s1_advance  = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_ready    = !s1_valid_q || s1_advance;
  assign in_if.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.valid && in_ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_ready) begin
      s1_item_q.btn_left_level   <= in_if.btn_left_level;
      s1_item_q.btn_right_level  <= in_if.btn_right_level;
      s1_item_q.btn_hazard_level <= in_if.btn_hazard_level;
      s1_item_q.remote_cmd       <= in_if.remote_cmd;
    end
  end

  tshc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_advance),
    .item_i          (s1_item_q),
    .sample_period_i (sample_period_q),
    .flash_half_i    (flash_half_q),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_res_q <= res_d;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.led_left       = out_res_q.led_left;
  assign out_if.led_right      = out_res_q.led_right;
  assign out_if.mode           = out_res_q.mode;
  assign out_if.status_reports = out_res_q.status_reports;

`ifndef NO_ASSERTIONS
  // Ready only drops with both stages full and the receiver stalling.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_valid_q && out_valid_q && !out_if.ready))
    else $error("input ready low without a full pipeline");

  // A lit lamp needs a mode other than off.
  a_lamp_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.led_left || out_res_q.led_right))
      |-> (out_res_q.mode != MODE_OFF))
    else $error("lamp lit while mode is off");

  // In hazard mode both lamps flash together.
  a_hazard_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.mode == MODE_HAZARD)
      |-> (out_res_q.led_left == out_res_q.led_right))
    else $error("hazard lamps out of step");

  // A sample period write lands in its register.
  a_cfg_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && paddr[2] == REG_IDX_SAMPLE)
      |=> (sample_period_q == $past(pwdata[SAMPLE_W-1:0])))
    else $error("sample period write lost");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tshc_checker.sv @@
// Checker that predicts the lamp status word of every tick and compares it on the output channel.
`timescale 1ns / 100ps

module tshc_checker
  import tshc_pkg::*;
#(
  parameter int TIMER_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tshc_in_if          tick_mon,
  tshc_out_if         lamp_mon,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);

  localparam int PRINT_CAP = 40;

  // Register copies, taken from the writes seen on the register port.
  logic [SAMPLE_W-1:0]   smp_period;
  logic [FLASH_W-1:0]    flash_half;

  // Controller state as the predictor sees it.
  tshc_mode_e            mode_q;
  logic                  phase_q;
  logic [TIMER_BITS-1:0] flash_cnt;
  logic [SAMPLE_W-1:0]   smp_cnt;
  logic [2:0]            prev_btn;  // {left, right, hazard}, 1 is released
  logic [CMD_W-1:0]      last_cmd;

  tshc_result_t          lamps_due[$];
  tshc_result_t          want;
  tshc_item_t            seen;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
    if (errors_o < PRINT_CAP) begin
      $display("[%0t] result %0d: %s is %0d, predicted %0d", $time, results_o, what, got,
               want_v);
    end
    errors_o++;
  endtask

  // A falling edge on a sampled button toggles its mode; switching on restarts the flash.
  function automatic logic [1:0] take_press(logic now, logic was, tshc_mode_e which);
    if (now || !was) return 2'd0;
    if (mode_q == which) begin
      mode_q = MODE_OFF;
    end else begin
      mode_q    = which;
      phase_q   = 1'b1;
      flash_cnt = '0;
    end
    return 2'd1;
  endfunction

  function automatic tshc_result_t predict_tick(tshc_item_t w);
    tshc_result_t r;
    logic [1:0]   presses;
    presses = 2'd0;
    if (smp_cnt != '1) smp_cnt++;
    if (flash_cnt != '1) flash_cnt++;
    if (w.remote_cmd != last_cmd) begin
      last_cmd = w.remote_cmd;
      if (w.remote_cmd <= CMD_MAX) begin
        mode_q    = tshc_mode_e'(w.remote_cmd[1:0]);
        phase_q   = 1'b1;
        flash_cnt = '0;
      end
    end
    if (smp_cnt >= smp_period) begin
      presses += take_press(w.btn_left_level, prev_btn[2], MODE_LEFT);
      presses += take_press(w.btn_right_level, prev_btn[1], MODE_RIGHT);
      presses += take_press(w.btn_hazard_level, prev_btn[0], MODE_HAZARD);
      prev_btn = {w.btn_left_level, w.btn_right_level, w.btn_hazard_level};
      smp_cnt  = '0;
    end
    if (flash_cnt >= flash_half) begin
      phase_q   = ~phase_q;
      flash_cnt = '0;
    end
    r.led_left       = phase_q && (mode_q == MODE_LEFT || mode_q == MODE_HAZARD);
    r.led_right      = phase_q && (mode_q == MODE_RIGHT || mode_q == MODE_HAZARD);
    r.mode           = mode_q;
    r.status_reports = presses;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_period = SAMPLE_PERIOD_RESET;
      flash_half = FLASH_HALF_RESET;
      mode_q     = MODE_OFF;
      phase_q    = 1'b0;
      flash_cnt  = '0;
      smp_cnt    = '0;
      prev_btn   = 3'b111;
      last_cmd   = '0;
      lamps_due.delete();
      errors_o   = 0;
      results_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_IDX_SAMPLE) smp_period = pwdata_i[SAMPLE_W-1:0];
        else flash_half = pwdata_i[FLASH_W-1:0];
      end
      if (lamp_mon.valid && lamp_mon.ready) begin
        results_o++;
        if (lamps_due.size() == 0) begin
          report_mismatch("word with no tick waiting, mode", lamp_mon.mode, 0);
        end else begin
          want = lamps_due.pop_front();
          if (lamp_mon.led_left !== want.led_left)
            report_mismatch("led_left", lamp_mon.led_left, want.led_left);
          if (lamp_mon.led_right !== want.led_right)
            report_mismatch("led_right", lamp_mon.led_right, want.led_right);
          if (lamp_mon.mode !== want.mode)
            report_mismatch("mode", lamp_mon.mode, want.mode);
          if (lamp_mon.status_reports !== want.status_reports)
            report_mismatch("status_reports", lamp_mon.status_reports, want.status_reports);
        end
      end
      if (tick_mon.valid && tick_mon.ready) begin
        seen.btn_left_level   = tick_mon.btn_left_level;
        seen.btn_right_level  = tick_mon.btn_right_level;
        seen.btn_hazard_level = tick_mon.btn_hazard_level;
        seen.remote_cmd       = tick_mon.remote_cmd;
        lamps_due.push_back(predict_tick(seen));
      end
    end
    pending_o = lamps_due.size();
  end

endmodule

@@ tb/sv/turn_signal_hazard_controller_tb.sv @@
// Testbench top: drives tick words and register writes into the controller and gives the verdict.
`timescale 1ns / 100ps

module turn_signal_hazard_controller_tb;
  import tshc_pkg::*;

  localparam int TIMER_BITS  = 14;
  // Length of the receiver hold-off; far more than the two words the block can buffer.
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 100000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tshc_in_if  tick_if ();
  tshc_out_if lamp_if ();

  int n_errors;
  int n_pending;
  int n_results;
  int n_settings;

  // Flow control knobs, in percent per cycle. The sender reads idle_pct, the receiver stall_pct.
  int   idle_pct;
  int   stall_pct;
  logic hold_req;

  // Shape of the random ticks. Buttons and the remote command are held like real
  // levels and change now and then; noise words scramble everything.
  int         cmd_pct;
  int         btn_pct;
  int         noise_pct;
  logic [2:0] held_btn;
  logic [7:0] held_cmd;

  always #5 clk_i = ~clk_i;

  turn_signal_hazard_controller #(
    .TIMER_BITS(TIMER_BITS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (tick_if),
    .out_if  (lamp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tshc_checker #(
    .TIMER_BITS(TIMER_BITS)
  ) u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_mon  (tick_if),
    .lamp_mon  (lamp_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .pready_i  (pready),
    .errors_o  (n_errors),
    .pending_o (n_pending),
    .results_o (n_results)
  );

  // One register write: a setup phase, then access until pready. The write
  // lands at the edge where psel, penable, pwrite and pready are all high.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes both periods. The bits above each register's width carry random junk,
  // which the block has to drop.
  task automatic set_periods(int sp, int fh);
    reg_write({REG_IDX_SAMPLE, 2'b00}, ($urandom & ~32'h3FF) | (sp & 32'h3FF));
    reg_write({REG_IDX_FLASH, 2'b00}, ($urandom & ~32'h3FFF) | (fh & 32'h3FFF));
    n_settings++;
  endtask

  // Offers one tick word after a random number of idle cycles and returns in the
  // time step of the edge that accepted it. Valid stays high between words that
  // follow each other without a gap.
  task automatic send_word(tshc_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid            <= 1'b1;
    tick_if.btn_left_level   <= w.btn_left_level;
    tick_if.btn_right_level  <= w.btn_right_level;
    tick_if.btn_hazard_level <= w.btn_hazard_level;
    tick_if.remote_cmd       <= w.remote_cmd;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // Lets every expected word come out, then waits out the two pipeline stages,
  // so that a register write never meets a tick in flight.
  task automatic wait_drained();
    int k;
    tick_if.valid <= 1'b0;
    k = 0;
    do begin
      @(posedge clk_i);
      k++;
    end while (n_pending != 0 && k < DRAIN_LIMIT);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic tshc_item_t tick(logic l, logic r, logic h, logic [7:0] cmd);
    return {l, r, h, cmd};
  endfunction

  function automatic tshc_item_t next_tick();
    tshc_item_t w;
    int         roll;
    roll = $urandom_range(99);
    if (roll < cmd_pct) held_cmd = 8'($urandom_range(3));
    else if (roll < 2 * cmd_pct) held_cmd = 8'($urandom_range(255));
    if ($urandom_range(99) < btn_pct) held_btn[$urandom_range(2)] ^= 1'b1;
    w = {held_btn, held_cmd};
    if ($urandom_range(99) < noise_pct) w = 11'($urandom);
    return w;
  endfunction

  task automatic run_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_word(next_tick());
    wait_drained();
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested. The hold-off
  // is counted here so the sender keeps offering words and the block backs up.
  initial begin
    lamp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        lamp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        lamp_if.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk_i);
      end
    end
  end

  // Hard stop in case the block hangs its handshake.
  initial begin
    #5_000_000;
    $display("turn_signal_hazard_controller_tb: done, errors");
    $finish;
  end

  initial begin
    rst_ni                   <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    tick_if.valid            <= 1'b0;
    tick_if.btn_left_level   <= 1'b1;
    tick_if.btn_right_level  <= 1'b1;
    tick_if.btn_hazard_level <= 1'b1;
    tick_if.remote_cmd       <= '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    cmd_pct    = 2;
    btn_pct    = 8;
    noise_pct  = 3;
    held_btn   = 3'b111;
    held_cmd   = '0;
    n_settings = 1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset periods of 50 and 500: buttons are sampled only every fiftieth tick.
    run_random(110, 0, 0);

    // Directed ticks with a sample every tick and a short flash, starting from
    // whatever state the random run before left.
    set_periods(1, 3);
    send_word(tick(1, 1, 1, 8'd0));    // all released, command 0
    send_word(tick(0, 1, 1, 8'd0));    // left press turns left on
    send_word(tick(0, 1, 1, 8'd0));    // held press is no new edge
    send_word(tick(1, 1, 1, 8'd0));
    send_word(tick(0, 1, 1, 8'd0));    // second left press turns it off again
    send_word(tick(1, 1, 1, 8'd0));
    send_word(tick(1, 0, 1, 8'd0));    // right
    send_word(tick(1, 1, 0, 8'd0));    // hazard over right; the right release is no edge
    send_word(tick(1, 1, 1, 8'd0));
    send_word(tick(1, 1, 0, 8'd0));    // hazard toggles off
    send_word(tick(1, 1, 1, 8'd0));
    send_word(tick(0, 0, 0, 8'd0));    // edges on all three buttons at once, hazard wins
    send_word(tick(1, 1, 1, 8'd1));    // remote left
    send_word(tick(1, 1, 1, 8'd2));    // remote right
    send_word(tick(1, 1, 1, 8'd3));    // remote hazard
    send_word(tick(1, 1, 1, 8'd3));    // repeated command is no change
    send_word(tick(1, 1, 1, 8'd0));    // remote off
    send_word(tick(1, 1, 1, 8'd255));  // unknown command, only remembered
    send_word(tick(1, 1, 1, 8'd255));
    send_word(tick(1, 1, 1, 8'd4));    // another unknown one
    send_word(tick(1, 1, 1, 8'd0));    // 0 after an unknown command is a change to off
    send_word(tick(0, 1, 1, 8'd128));  // unknown command plus a left press
    send_word(tick(1, 1, 1, 8'd128));
    send_word(tick(0, 1, 1, 8'd1));    // remote left, then the left press turns it off
    send_word(tick(1, 0, 1, 8'd1));
    wait_drained();

    // Random ticks, no idling.
    cmd_pct = 8;
    run_random(150, 0, 0);

    // Zero periods: buttons are sampled and the flash toggles on every tick. Sender gaps.
    set_periods(0, 0);
    run_random(120, 57, 0);

    // Receiver stalls, with one long hold-off at the start that fills the block.
    set_periods(2, 7);
    hold_req = 1'b1;
    run_random(150, 0, 57);

    // Both sides idle a little.
    set_periods(7, 40);
    run_random(150, 8, 8);

    // Long periods; no command changes so the flash can run.
    set_periods(400, 250);
    cmd_pct   = 0;
    btn_pct   = 1;
    noise_pct = 0;
    run_random(450, 0, 0);

    // Short periods again, gaps and stalls on both sides.
    set_periods(3, 5);
    cmd_pct   = 8;
    btn_pct   = 8;
    noise_pct = 4;
    run_random(100, 57, 57);

    wait_drained();
    if (n_pending != 0) $display("%0d predicted words never came out", n_pending);
    $display("Covered %0d ticks over %0d period settings, from zero up to 400 and 500.",
             n_results, n_settings);
    $display("Flow control ran free, with sender gaps, receiver stalls, both, and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (n_errors == 0 && n_pending == 0) begin
      $display("turn_signal_hazard_controller_tb: done, clean");
    end else begin
      $display("turn_signal_hazard_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
